@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file tkf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ design/tkf_pkg.sv @@
package tkf_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_FB = 30;
  localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] DEG2RAD_Q30 = 64'sd18740330;
  localparam logic signed [63:0] RAD2DEG_Q24 = 64'sd961263669;
  localparam logic [63:0] US_PER_S = 64'd1000000;
  localparam int CNT_W = 7;

  // dt = diff * 2^16 / 10^6 = diff * 1024 / 15625. The division by 15625 is a
  // multiplication by ceil(2^46 / 15625) and a shift by 46, exact for 32-bit operands.
  localparam logic [32:0] DT_RECIP = 33'd4503599628;
  localparam logic [31:0] DT_DIV = 32'd15625;

  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_GYRO = 2'd1;
  localparam logic [1:0] REG_R_ANGLE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DT, ST_CORDIC, ST_MEAS, ST_RATE, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_P6, ST_P7, ST_P8, ST_S, ST_DIV0, ST_DIV1, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5,
    ST_U6, ST_OUT, ST_HOLD
  } state_t;

  typedef struct packed {
    state_t step;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_zero;
  } sts_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: return 32'sh3243F6A8;
      5'd1: return 32'sh1DAC6705;
      5'd2: return 32'sh0FADBAFC;
      5'd3: return 32'sh07F56EA6;
      5'd4: return 32'sh03FEAB76;
      5'd5: return 32'sh01FFD55B;
      5'd6: return 32'sh00FFFAAA;
      5'd7: return 32'sh007FFF55;
      5'd8: return 32'sh003FFFEA;
      5'd9: return 32'sh001FFFFD;
      5'd10: return 32'sh000FFFFF;
      5'd11: return 32'sh0007FFFF;
      5'd12: return 32'sh0003FFFF;
      5'd13: return 32'sh0001FFFF;
      5'd14: return 32'sh0000FFFF;
      5'd15: return 32'sh00007FFF;
      5'd16: return 32'sh00003FFF;
      5'd17: return 32'sh00001FFF;
      5'd18: return 32'sh00000FFF;
      5'd19: return 32'sh000007FF;
      5'd20: return 32'sh000003FF;
      5'd21: return 32'sh000001FF;
      5'd22: return 32'sh000000FF;
      5'd23: return 32'sh0000007F;
      default: return 32'sh0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic logic signed [31:0] reg_val(input logic [31:0] r);
    return r[31] ? 32'sh7FFFFFFF : $signed(r);
  endfunction
endpackage

@@ design/tkf_ctrl.sv @@
module tkf_ctrl import tkf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_DT;
      ST_DT: if (sts.done) state_next = ST_CORDIC;
      ST_CORDIC: if (sts.done) state_next = ST_MEAS;
      ST_MEAS: state_next = ST_RATE;
      ST_RATE: state_next = ST_P1;
      ST_P1: state_next = ST_P2;
      ST_P2: state_next = ST_P3;
      ST_P3: state_next = ST_P4;
      ST_P4: state_next = ST_P5;
      ST_P5: state_next = ST_P6;
      ST_P6: state_next = ST_P7;
      ST_P7: state_next = ST_P8;
      ST_P8: state_next = ST_S;
      ST_S: state_next = sts.s_zero ? ST_OUT : ST_DIV0;
      ST_DIV0: if (sts.done) state_next = ST_DIV1;
      ST_DIV1: if (sts.done) state_next = ST_U1;
      ST_U1: state_next = ST_U2;
      ST_U2: state_next = ST_U3;
      ST_U3: state_next = ST_U4;
      ST_U4: state_next = ST_U5;
      ST_U5: state_next = ST_U6;
      ST_U6: state_next = ST_OUT;
      ST_OUT: state_next = ST_HOLD;
      ST_HOLD: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.step = state;
    busy = (state != ST_IDLE);
    out_valid = (state == ST_HOLD);
  end
endmodule

@@ design/tkf_datapath.sv @@
module tkf_datapath import tkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic        [31:0] sample_time_us,
  input  logic signed [31:0] gyro_rate,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic               cfg_we,
  input  logic         [1:0] cfg_idx,
  input  logic        [31:0] cfg_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic signed [31:0] roll_deg
);
  logic [31:0] q_angle, q_gyro, r_angle, prev_time;
  logic signed [31:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [31:0] gyro_r, dt, meas, rate, s_val, k0, k1, innov, tmp;
  logic signed [15:0] ay_r, az_r;
  logic [CNT_W-1:0] cnt;
  logic signed [47:0] cx, cy;
  logic signed [63:0] cz;
  logic [63:0] rem, quo;
  logic [63:0] div_den;
  logic div_neg;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] mres;
  logic signed [63:0] big_prod;
  logic [4:0] ci;
  logic signed [47:0] xs, ys;
  logic [64:0] trial;
  logic [31:0] dt_diff, dt_r1;
  logic [18:0] dt_q1;
  logic [64:0] dt_prod;

  assign ci = cnt[4:0];
  assign xs = cx >>> ci;
  assign ys = cy >>> ci;
  assign prod = 64'(ma) * 64'(mb);
  assign mres = sat32(66'(prod >>> FRAC_BITS));
  assign trial = {rem, quo[63]} - {1'b0, div_den};
  assign dt_prod = 65'(dt_diff) * 65'(DT_RECIP);
  assign dt_r1 = dt_diff - 32'(dt_q1) * DT_DIV;

  always_comb begin
    ma = dt;
    mb = tmp;
    unique case (cmd.step)
      ST_P1: begin ma = dt; mb = sub_s(rate, bias_est); end
      ST_P2: begin ma = dt; mb = add_s(cov_ba, cov_ab); end
      ST_P3: begin ma = reg_val(q_angle); mb = dt; end
      ST_P4, ST_P5: begin ma = dt; mb = cov_bb; end
      ST_P6: begin ma = reg_val(q_gyro); mb = dt; end
      ST_U1: begin ma = k0; mb = innov; end
      ST_U2: begin ma = k1; mb = innov; end
      ST_U3: begin ma = k1; mb = cov_aa; end
      ST_U4: begin ma = k1; mb = cov_ab; end
      ST_U5: begin ma = k0; mb = cov_aa; end
      ST_U6: begin ma = k0; mb = cov_ab; end
      default: begin ma = dt; mb = tmp; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= 32'd66;
      q_gyro <= 32'd197;
      r_angle <= 32'd1966;
      prev_time <= '0;
      angle_est <= '0;
      bias_est <= '0;
      cov_aa <= '0;
      cov_ab <= '0;
      cov_ba <= '0;
      cov_bb <= '0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_Q_ANGLE: q_angle <= cfg_data;
          REG_Q_GYRO: q_gyro <= cfg_data;
          REG_R_ANGLE: r_angle <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        dt_diff <= sample_time_us - prev_time;
        prev_time <= sample_time_us;
        gyro_r <= gyro_rate;
        ay_r <= accel_y;
        az_r <= accel_z;
        cnt <= '0;
      end
      unique case (cmd.step)
        ST_DT: begin
          if (cnt == CNT_W'(0)) begin
            dt_q1 <= dt_prod[64:46];
            cnt <= cnt + 1'b1;
          end else if (cnt == CNT_W'(1)) begin
            dt_diff <= {dt_r1[21:0], 10'd0};
            cnt <= cnt + 1'b1;
          end else begin
            dt <= {3'd0, dt_q1, 10'd0} + {13'd0, dt_prod[64:46]};
            cx <= 48'(ay_r) <<< 14;
            cy <= -(48'(az_r) <<< 14);
            cz <= '0;
            cnt <= '0;
          end
        end
        ST_DIV0, ST_DIV1: begin
          if (cnt != CNT_W'(64)) begin
            if (!trial[64]) begin
              rem <= trial[63:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], quo[63]};
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
          end else begin
            cnt <= '0;
            if (cmd.step == ST_DIV0) begin
              k0 <= sat32(div_neg ? -66'(quo) : 66'(quo));
              rem <= '0;
              quo <= cov_ba[31] ? 64'(-(64'(cov_ba))) << FRAC_BITS
                                : 64'(cov_ba) << FRAC_BITS;
              div_neg <= cov_ba[31] ^ s_val[31];
            end else begin
              k1 <= sat32(div_neg ? -66'(quo) : 66'(quo));
            end
          end
        end
        ST_CORDIC: begin
          if (cnt == '0 && cx < 0) begin
            cz <= (cy >= 0) ? PI_Q30 : -PI_Q30;
            cx <= -cx;
            cy <= -cy;
          end else if (cnt != CNT_W'(CORDIC_STEPS)) begin
            if (cy >= 0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + 64'(atan_q30(ci));
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - 64'(atan_q30(ci));
            end
            cnt <= cnt + 1'b1;
          end
        end
        ST_MEAS: begin
          if (ay_r == 0 && az_r == 0) cz <= HALF_PI_Q30;
          else cz <= HALF_PI_Q30 - cz;
          big_prod <= 64'(gyro_r) * DEG2RAD_Q30;
        end
        ST_RATE: begin
          meas <= sat32(66'(cz >>> (ANG_FB - FRAC_BITS)));
          rate <= sat32(66'(big_prod >>> ANG_FB));
        end
        ST_P1: angle_est <= add_s(angle_est, mres);
        ST_P2: tmp <= sub_s(cov_aa, mres);
        ST_P3: cov_aa <= add_s(tmp, mres);
        ST_P4: cov_ab <= sub_s(cov_ab, mres);
        ST_P5: cov_ba <= sub_s(cov_ba, mres);
        ST_P6: cov_bb <= add_s(cov_bb, mres);
        ST_P7: s_val <= add_s(cov_aa, reg_val(r_angle));
        ST_P8: innov <= sub_s(meas, angle_est);
        ST_S: begin
          rem <= '0;
          quo <= cov_aa[31] ? 64'(-(64'(cov_aa))) << FRAC_BITS
                            : 64'(cov_aa) << FRAC_BITS;
          div_den <= s_val[31] ? 64'(-(64'(s_val))) : 64'(s_val);
          div_neg <= cov_aa[31] ^ s_val[31];
          cnt <= '0;
        end
        ST_U1: angle_est <= add_s(angle_est, mres);
        ST_U2: bias_est <= add_s(bias_est, mres);
        ST_U3: cov_ba <= sub_s(cov_ba, mres);
        ST_U4: cov_bb <= sub_s(cov_bb, mres);
        ST_U5: cov_aa <= sub_s(cov_aa, mres);
        ST_U6: cov_ab <= sub_s(cov_ab, mres);
        ST_OUT: big_prod <= 64'(angle_est) * RAD2DEG_Q24;
        default: ;
      endcase
    end
  end

  assign roll_deg = sat32(66'(big_prod >>> 24));
  assign sts.s_zero = (s_val == 0);
  assign sts.done = (cmd.step == ST_CORDIC) ? (cnt == CNT_W'(CORDIC_STEPS))
                  : (cmd.step == ST_DT) ? (cnt == CNT_W'(2))
                  : (cnt == CNT_W'(64));
endmodule

@@ design/tilt_kalman_angle_bias_filter_unit.sv @@
// Roll estimator: one IMU sample in, one filtered roll angle out in degrees (Q16.16).
// A sample is processed in order: dt by reciprocal multiplication, the CORDIC in 16
// steps (after a first rotation by pi when accel_y is negative), the prediction, the two
// 64-step radix-2 divisions for the Kalman gains, which share one divider, and the update.
// When the innovation variance is zero the gains and the update are skipped. The next
// sample is taken in the cycle after the result transaction.
module tilt_kalman_angle_bias_filter_unit import tkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [31:0] sample_time_us,
  input  logic signed [31:0] gyro_rate,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] roll_deg,
  input  logic               cfg_we,
  input  logic         [1:0] cfg_idx,
  input  logic        [31:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  tkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_valid && out_ready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  tkf_datapath u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sample_time_us(sample_time_us),
    .gyro_rate(gyro_rate), .accel_y(accel_y), .accel_z(accel_z), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .roll_deg(roll_deg)
  );
endmodule

@@ design/tkf_checker.sv @@
`include "assert_macros.svh"
module tkf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] roll_deg
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(roll_deg), "result dropped")
  `CHK_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `CHK_NEXT(a_no_instant, clk, rst, in_valid && in_ready, !out_valid, "result without work")
endmodule

bind tilt_kalman_angle_bias_filter_unit tkf_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .roll_deg(roll_deg)
);

@@ sim/tilt_kalman_angle_bias_filter_unit_checker.sv @@
`timescale 1ns / 1ps

module tilt_kalman_angle_bias_filter_unit_checker import tkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [31:0] sample_time_us,
  input  logic signed [31:0] gyro_rate,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] roll_deg,
  input  logic               cfg_we,
  input  logic         [1:0] cfg_idx,
  input  logic        [31:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  logic [31:0] noise_angle, noise_gyro, noise_meas;
  int angle, bias, p_aa, p_ab, p_ba, p_bb;
  logic [31:0] last_us;
  int roll_q[$];

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int sadd(int a, int b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic int ssub(int a, int b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic int smul(int a, int b);
    return clamp32((longint'(a) * longint'(b)) >>> FRAC_BITS);
  endfunction

  function automatic int sdiv(int a, int b);
    return clamp32((longint'(a) <<< FRAC_BITS) / longint'(b));
  endfunction

  function automatic int reg_limit(logic [31:0] r);
    return r[31] ? 32'sh7FFFFFFF : int'(r);
  endfunction

  // Vectoring rotation; returns atan2(yy, xx) with 30 fraction bits.
  function automatic longint vector_angle(longint yy, longint xx);
    longint x, y, z, xs, ys;
    x = xx * 16384;
    y = yy * 16384;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_q30(5'(i)));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_q30(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic int filter_roll(logic [31:0] now_us, int rate_dps,
                                     int ay, int az);
    logic [63:0] dq;
    int dt, rate, meas, s, k0, k1, innov, old_aa, old_ab, qa, qg, ra;
    qa = reg_limit(noise_angle);
    qg = reg_limit(noise_gyro);
    ra = reg_limit(noise_meas);
    dq = {32'd0, 32'(now_us - last_us)} << FRAC_BITS;
    dq = dq / US_PER_S;
    dt = (dq > 64'd2147483647) ? 32'sh7FFFFFFF : int'(dq);
    last_us = now_us;
    meas = clamp32((HALF_PI_Q30 - vector_angle(-longint'(az), longint'(ay)))
                   >>> (ANG_FB - FRAC_BITS));
    rate = clamp32((longint'(rate_dps) * DEG2RAD_Q30) >>> ANG_FB);
    angle = sadd(angle, smul(dt, ssub(rate, bias)));
    p_aa = sadd(ssub(p_aa, smul(dt, sadd(p_ba, p_ab))), smul(qa, dt));
    p_ab = ssub(p_ab, smul(dt, p_bb));
    p_ba = ssub(p_ba, smul(dt, p_bb));
    p_bb = sadd(p_bb, smul(qg, dt));
    s = sadd(p_aa, ra);
    if (s != 0) begin
      innov = ssub(meas, angle);
      k0 = sdiv(p_aa, s);
      k1 = sdiv(p_ba, s);
      angle = sadd(angle, smul(k0, innov));
      bias = sadd(bias, smul(k1, innov));
      old_aa = p_aa;
      old_ab = p_ab;
      p_aa = ssub(p_aa, smul(k0, old_aa));
      p_ab = ssub(p_ab, smul(k0, old_ab));
      p_ba = ssub(p_ba, smul(k1, old_aa));
      p_bb = ssub(p_bb, smul(k1, old_ab));
    end
    return clamp32((longint'(angle) * RAD2DEG_Q24) >>> 24);
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    int want;
    if (rst) begin
      noise_angle = 32'd66;
      noise_gyro = 32'd197;
      noise_meas = 32'd1966;
      angle = 0; bias = 0;
      p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      last_us = '0;
      roll_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_Q_ANGLE: noise_angle = cfg_data;
          REG_Q_GYRO:  noise_gyro = cfg_data;
          REG_R_ANGLE: noise_meas = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        roll_q.push_back(filter_roll(sample_time_us, gyro_rate, accel_y, accel_z));
      if (out_valid && out_ready) begin
        if (roll_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, roll_deg %0d",
                   $time, roll_deg);
          errors++;
        end else begin
          want = roll_q.pop_front();
          if (roll_deg !== want) report("roll_deg", roll_deg, want);
        end
      end
      pending = roll_q.size();
    end
  end

endmodule

@@ sim/tilt_kalman_angle_bias_filter_unit_test.sv @@
`timescale 1ns / 1ps

module tilt_kalman_angle_bias_filter_unit_test import tkf_pkg::*;;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] sample_time_us = '0;
  logic signed [31:0] gyro_rate = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] roll_deg;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int errors, pending;
  int hold_cycles = 0;
  int stall_mode = 0;
  int idle_count = 0;
  logic [31:0] clock_us = '0;

  always #10 clk = ~clk;

  tilt_kalman_angle_bias_filter_unit dut (.*);

  tilt_kalman_angle_bias_filter_unit_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    @(negedge clk);
    forever begin
      if (rst) out_ready = 1'b0;
      else if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else case (stall_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(3) != 0);
        default: out_ready = ($urandom_range(4) == 0);
      endcase
      @(negedge clk);
    end
  end

  task automatic send(logic [31:0] t, logic [31:0] g, logic [15:0] y, logic [15:0] z);
    sample_time_us = t;
    gyro_rate = g;
    accel_y = y;
    accel_z = z;
    in_valid = 1'b1;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_regs(logic [31:0] qa, logic [31:0] qg, logic [31:0] ra);
    cfg_we = 1'b1;
    cfg_idx = REG_Q_ANGLE; cfg_data = qa; @(negedge clk);
    cfg_idx = REG_Q_GYRO;  cfg_data = qg; @(negedge clk);
    cfg_idx = REG_R_ANGLE; cfg_data = ra; @(negedge clk);
    cfg_idx = REG_UNUSED;  cfg_data = $urandom(); @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_sample();
    logic [31:0] g;
    logic [15:0] y, z;
    int k;
    k = $urandom_range(9);
    if (k == 0) clock_us = $urandom();
    else clock_us = clock_us + $urandom_range(20000, 1);
    if (k < 2) g = $urandom();
    else g = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    if (k < 7) begin
      y = 16'($urandom());
      z = 16'($urandom());
    end else begin
      y = 16'($signed($urandom_range(0, 4000)) - 2000);
      z = 16'($signed($urandom_range(0, 4000)) + 14000);
    end
    send(clock_us, g, y, z);
  endtask

  task automatic random_phase(int n, int mode);
    stall_mode = mode;
    for (int i = 0; i < n; i++) begin
      random_sample();
      if ($urandom_range(5) == 0) pause($urandom_range(300, 1));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    write_regs(32'd66, 32'd197, 32'd1966);

    send(32'd0, 32'd0, 16'sd0, 16'sd0);
    send(32'd5000, 32'sh7FFFFFFF, 16'sd16384, 16'sd0);
    send(32'd10000, 32'sh80000000, -16'sd16384, 16'sd0);
    send(32'd12000, 32'h00010000, 16'sd32767, -16'sd32768);
    send(32'd14000, 32'hFFFF0000, -16'sd32768, 16'sd32767);
    send(32'd16000, 32'd0, 16'sd0, 16'sd32767);
    send(32'd18000, 32'd0, 16'sd0, -16'sd32768);
    send(32'd18000, 32'd12345, -16'sd1, -16'sd1);
    send(32'hFFFFFFFF, 32'hAAAAAAAA, 16'h5555, 16'hAAAA);
    send(32'd100, 32'h55555555, 16'hAAAA, 16'h5555);
    send(32'h80000000, 32'd1, 16'sd1, 16'sd1);
    send(32'h80001000, 32'd0, 16'sd32767, 16'sd32767);
    send(32'h80002000, 32'd0, -16'sd32768, -16'sd32768);
    clock_us = 32'h80002000;
    drain();

    write_regs(32'd0, 32'd0, 32'd0);
    send(clock_us, 32'd0, 16'sd100, 16'sd16000);
    send(clock_us, 32'd0, 16'sd100, 16'sd16000);
    send(clock_us + 1000, 32'h00100000, 16'sd0, 16'sd0);
    clock_us = clock_us + 1000;
    random_phase(120, 1);
    drain();

    write_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    hold_cycles = 2000;
    random_phase(130, 2);
    drain();

    write_regs(32'h7FFFFFFF, 32'd0, 32'd1);
    random_phase(130, 0);
    drain();

    write_regs(32'h80000000, 32'd1, 32'h7FFFFFFF);
    random_phase(130, 1);
    drain();

    write_regs($urandom_range(4000), $urandom_range(4000), $urandom_range(40000));
    random_phase(140, 1);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
